// ----- design/dpmm_pkg.sv -----
// Shared constants and types for the divisor-path multinomial block.
package dpmm_pkg;

    localparam int DATA_W          = 50;
    localparam int RES_W           = 30;
    localparam int CFG_W           = 5;
    localparam int SLOT_W          = 4;
    localparam int CNT_W           = 6;
    localparam int DEF_MAX_PRIMES  = 16;

    localparam logic [RES_W-1:0] MODULUS = 30'd998244353;
    localparam logic [RES_W-1:0] MOD_EXP = MODULUS - 30'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] value;
    } t_lane_stat;

endpackage

// ----- design/dpmm_modmul.sv -----
// Bit-serial modular multiplier, one bit of the first operand per cycle.
module dpmm_modmul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [dpmm_pkg::RES_W-1:0] i_a,
    input  logic [dpmm_pkg::RES_W-1:0] i_b,
    output logic                  o_done,
    output logic [dpmm_pkg::RES_W-1:0] o_result
);
    import dpmm_pkg::*;

    logic [RES_W-1:0] r_acc, n_acc;
    logic [RES_W-1:0] r_a;
    logic [RES_W-1:0] r_b;
    logic [4:0]       r_i;
    logic             r_busy;
    logic             r_done;
    logic [RES_W+1:0] t0, t1;

    always_comb begin
        t0 = {1'b0, r_acc, 1'b0} + (r_a[r_i] ? {2'b00, r_b} : '0);
        t1 = (t0 >= {2'b00, MODULUS}) ? t0 - {2'b00, MODULUS} : t0;
        if (t1 >= {2'b00, MODULUS}) begin
            t1 = t1 - {2'b00, MODULUS};
        end
        n_acc = t1[RES_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_i    <= 5'(RES_W - 1);
            end else if (r_busy) begin
                r_acc <= n_acc;
                if (r_i == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i - 5'd1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;
endmodule

// ----- design/dpmm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module dpmm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dpmm_pkg::DATA_W-1:0] i_dividend,
    input  logic [dpmm_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [dpmm_pkg::DATA_W-1:0] o_quotient,
    output logic [dpmm_pkg::DATA_W-1:0] o_remainder
);
    import dpmm_pkg::*;

    logic [DATA_W-1:0] r_rem, r_quo, r_dvs;
    logic [CNT_W-1:0]  r_i;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   t;
    logic              ge;

    always_comb begin
        t  = {r_rem, r_quo[DATA_W-1]};
        ge = (t >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_i    <= CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                r_rem <= ge ? DATA_W'(t - {1'b0, r_dvs}) : t[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], ge};
                if (r_i == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i - CNT_W'(1);
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// ----- design/dpmm_lane.sv -----
// One lane: reduces its value by the gcd, factors it and forms its multinomial.
module dpmm_lane #(
    parameter int MAX_PRIMES = dpmm_pkg::DEF_MAX_PRIMES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dpmm_pkg::t_tbl_wr           i_tbl_wr,
    input  logic                        i_start,
    input  logic [dpmm_pkg::DATA_W-1:0] i_value,
    input  logic [dpmm_pkg::DATA_W-1:0] i_gcd,
    input  logic [dpmm_pkg::CFG_W-1:0]  i_used,
    output dpmm_pkg::t_lane_stat        o_stat
);
    import dpmm_pkg::*;

    localparam int IDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

    typedef enum logic [3:0] {
        L_IDLE, L_QDIV, L_ZERO, L_FETCH, L_TEST, L_FDIV,
        L_MDEN, L_MNUM, L_PREP, L_PWR, L_PWRW, L_PWB, L_DONE
    } t_lstate;

    t_lstate           r_state;
    logic [DATA_W-1:0] r_mem [MAX_PRIMES];
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] r_n;
    logic [CFG_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_cnt, r_tot;
    logic [RES_W-1:0]  r_den, r_num, r_base, r_res;
    logic [4:0]        r_bit;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_a, div_b, div_q, div_r;
    logic              mul_start, mul_done;
    logic [RES_W-1:0]  mul_a, mul_b, mul_res;

    always_ff @(posedge i_clk) begin
        if (i_tbl_wr.we) begin
            r_mem[i_tbl_wr.addr[IDX_W-1:0]] <= i_tbl_wr.data;
        end
        r_rd <= r_mem[r_k[IDX_W-1:0]];
    end

    always_comb begin
        div_start = 1'b0;
        div_a     = r_n;
        div_b     = r_rd;
        mul_start = 1'b0;
        mul_a     = r_base;
        mul_b     = r_base;
        unique case (r_state)
            L_IDLE, L_DONE: begin
                div_start = i_start;
                div_a     = i_value;
                div_b     = i_gcd;
            end
            L_TEST: begin
                div_start = (r_rd >= DATA_W'(2));
            end
            L_FDIV: begin
                mul_start = div_done && (div_r == '0);
                mul_a     = r_den;
                mul_b     = RES_W'(r_cnt) + RES_W'(1);
            end
            L_MDEN: begin
                mul_start = mul_done;
                mul_a     = r_num;
                mul_b     = RES_W'(r_tot);
            end
            L_PWR: begin
                mul_start = 1'b1;
                if (MOD_EXP[r_bit]) begin
                    mul_a = r_res;
                end
            end
            L_PWRW: begin
                mul_start = mul_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                L_IDLE, L_DONE: begin
                    if (i_start) begin
                        r_state <= L_QDIV;
                    end
                end
                L_QDIV: begin
                    if (div_done) begin
                        r_n     <= div_q;
                        r_state <= L_ZERO;
                    end
                end
                L_ZERO: begin
                    r_k   <= '0;
                    r_cnt <= '0;
                    r_tot <= '0;
                    r_den <= RES_W'(1);
                    r_num <= RES_W'(1);
                    if (r_n == '0) begin
                        r_res   <= RES_W'(1);
                        r_state <= L_DONE;
                    end else begin
                        r_state <= L_FETCH;
                    end
                end
                L_FETCH: begin
                    r_state <= (r_k >= i_used) ? L_PREP : L_TEST;
                end
                L_TEST: begin
                    if (r_rd < DATA_W'(2)) begin
                        r_k     <= r_k + CFG_W'(1);
                        r_cnt   <= '0;
                        r_state <= L_FETCH;
                    end else begin
                        r_state <= L_FDIV;
                    end
                end
                L_FDIV: begin
                    if (div_done) begin
                        if (div_r == '0) begin
                            r_n     <= div_q;
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_tot   <= r_tot + CNT_W'(1);
                            r_state <= L_MDEN;
                        end else begin
                            r_k     <= r_k + CFG_W'(1);
                            r_cnt   <= '0;
                            r_state <= L_FETCH;
                        end
                    end
                end
                L_MDEN: begin
                    if (mul_done) begin
                        r_den   <= mul_res;
                        r_state <= L_MNUM;
                    end
                end
                L_MNUM: begin
                    if (mul_done) begin
                        r_num   <= mul_res;
                        r_state <= L_TEST;
                    end
                end
                L_PREP: begin
                    // The numerator seeds the power loop, saving one multiply.
                    r_res   <= r_num;
                    r_base  <= r_den;
                    r_bit   <= '0;
                    r_state <= L_PWR;
                end
                L_PWR: begin
                    r_state <= MOD_EXP[r_bit] ? L_PWRW : L_PWB;
                end
                L_PWRW: begin
                    if (mul_done) begin
                        r_res   <= mul_res;
                        r_state <= L_PWB;
                    end
                end
                L_PWB: begin
                    if (mul_done) begin
                        r_base <= mul_res;
                        if (r_bit == 5'(RES_W - 1)) begin
                            r_state <= L_DONE;
                        end else begin
                            r_bit   <= r_bit + 5'd1;
                            r_state <= L_PWR;
                        end
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    dpmm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    dpmm_modmul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    assign o_stat.done  = (r_state == L_DONE);
    assign o_stat.value = r_res;
endmodule

// ----- design/divisor_path_multinomial_mod.sv -----
// Top level: prime table loads, gcd, two factoring lanes and the merging multiply.
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready | i_func, i_prime_index, i_prime_value,
//          |           |                         | i_first_value, i_second_value
//  out     | output    | o_out_valid/i_out_ready | o_path_count
//  cfg     | input     | i_cfg_we                | i_cfg_data (prime_count)
//
// A load beat writes the named table slot when it is in range. A query with equal values
// goes straight to its result of one; otherwise the binary gcd, a division per lane, a trial
// division per usable prime plus one per found factor, two multiplies per found factor, a
// 30-step modular power and the merging multiply set its length, which grows with the factors.
// Reset is synchronous and clears control state; table contents stay undefined.
// A held result does not stop the next beat being taken; a query stalls only at its end.
module divisor_path_multinomial_mod #(
    parameter int MAX_PRIMES = dpmm_pkg::DEF_MAX_PRIMES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [dpmm_pkg::SLOT_W-1:0] i_prime_index,
    input  logic [dpmm_pkg::DATA_W-1:0] i_prime_value,
    input  logic [dpmm_pkg::DATA_W-1:0] i_first_value,
    input  logic [dpmm_pkg::DATA_W-1:0] i_second_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [dpmm_pkg::RES_W-1:0]  o_path_count,
    input  logic                        i_cfg_we,
    input  logic [dpmm_pkg::CFG_W-1:0]  i_cfg_data
);
    import dpmm_pkg::*;

    localparam logic [CFG_W-1:0] MAXP = CFG_W'(MAX_PRIMES);

    typedef enum logic [2:0] {S_IDLE, S_GCD, S_GO, S_LANE, S_MRG, S_FIN} t_state;

    t_state            r_state;
    logic [CFG_W-1:0]  r_count;
    logic [CFG_W-1:0]  used;
    logic [DATA_W-1:0] r_u, r_v, r_a, r_b, r_g;
    logic [CNT_W-1:0]  r_sh;
    logic [RES_W-1:0]  r_res;
    logic              r_out_valid;
    logic [RES_W-1:0]  r_path_count;
    logic              accept;
    logic              fin_load;
    t_tbl_wr           tbl_wr;
    t_lane_stat        stat0, stat1;
    logic              lane_start;
    logic              mul_start, mul_done;
    logic [RES_W-1:0]  mul_res;

    assign used       = (r_count > MAXP) ? MAXP : r_count;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign lane_start = (r_state == S_GO);
    assign mul_start  = (r_state == S_LANE) && stat0.done && stat1.done;
    assign fin_load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        tbl_wr.we   = accept && (i_func == FUNC_LOAD)
                      && ({1'b0, i_prime_index} < MAXP);
        tbl_wr.addr = i_prime_index;
        tbl_wr.data = i_prime_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_func == FUNC_QUERY)) begin
                        r_u  <= i_first_value;
                        r_v  <= i_second_value;
                        r_a  <= i_first_value;
                        r_b  <= i_second_value;
                        r_sh <= '0;
                        if (i_first_value == i_second_value) begin
                            r_res   <= RES_W'(1);
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    // Binary gcd, one shift or subtract per cycle.
                    if (r_a == '0) begin
                        r_g     <= r_b << r_sh;
                        r_state <= S_GO;
                    end else if (r_b == '0) begin
                        r_g     <= r_a << r_sh;
                        r_state <= S_GO;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a  <= r_a >> 1;
                        r_b  <= r_b >> 1;
                        r_sh <= r_sh + CNT_W'(1);
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a >= r_b) begin
                        r_a <= r_a - r_b;
                    end else begin
                        r_b <= r_b - r_a;
                    end
                end
                S_GO: begin
                    r_state <= S_LANE;
                end
                S_LANE: begin
                    if (stat0.done && stat1.done) begin
                        r_state <= S_MRG;
                    end
                end
                S_MRG: begin
                    if (mul_done) begin
                        r_res   <= mul_res;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_path_count <= r_res;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    dpmm_lane #(.MAX_PRIMES(MAX_PRIMES)) u_lane0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tbl_wr (tbl_wr),
        .i_start  (lane_start),
        .i_value  (r_u),
        .i_gcd    (r_g),
        .i_used   (used),
        .o_stat   (stat0)
    );

    dpmm_lane #(.MAX_PRIMES(MAX_PRIMES)) u_lane1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tbl_wr (tbl_wr),
        .i_start  (lane_start),
        .i_value  (r_v),
        .i_gcd    (r_g),
        .i_used   (used),
        .o_stat   (stat1)
    );

    dpmm_modmul u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (stat0.value),
        .i_b      (stat1.value),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    assign o_out_valid  = r_out_valid;
    assign o_path_count = r_path_count;
endmodule
